// File: src/sha256_byte_stream_hasher_macros.svh
// Assertion macros shared by the hasher's checker.
`ifndef SHA256_BYTE_STREAM_HASHER_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_MACROS_SVH

// Clocked property, switched off while reset is held.
`define SBH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked property that also holds across reset.
`define SBH_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: src/sbh_pkg.sv
// Shared types, constants and SHA-256 functions for the byte stream hasher.
`timescale 1ns / 1ps

package sbh_pkg;

    localparam logic [7:0] PadByte = 8'h80;
    localparam logic [5:0] LenPos  = 6'd56;

    // Control from the sequencer to the round engine.
    typedef struct packed {
        logic       load_shift;
        logic       add_shift;
        logic       round_en;
        logic [5:0] rnd;
    } t_core_ctl;

    // Control for the hash state memory.
    typedef struct packed {
        logic [2:0]  raddr;
        logic        we;
        logic        clr;
        logic [2:0]  waddr;
        logic [31:0] wdata;
    } t_hmem_ctl;

    // Control for the block memory.
    typedef struct packed {
        logic [3:0]  raddr;
        logic        we;
        logic [3:0]  waddr;
        logic [31:0] wdata;
    } t_bmem_ctl;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_s0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_s1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_s0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_s1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] iv_const(input logic [2:0] idx);
        logic [31:0] v;
        unique case (idx)
            3'd0: v = 32'h6a09e667;
            3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372;
            3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f;
            3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab;
            3'd7: v = 32'h5be0cd19;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] k_const(input logic [5:0] idx);
        logic [31:0] v;
        unique case (idx)
            6'd0:  v = 32'h428a2f98;  6'd1:  v = 32'h71374491;
            6'd2:  v = 32'hb5c0fbcf;  6'd3:  v = 32'he9b5dba5;
            6'd4:  v = 32'h3956c25b;  6'd5:  v = 32'h59f111f1;
            6'd6:  v = 32'h923f82a4;  6'd7:  v = 32'hab1c5ed5;
            6'd8:  v = 32'hd807aa98;  6'd9:  v = 32'h12835b01;
            6'd10: v = 32'h243185be;  6'd11: v = 32'h550c7dc3;
            6'd12: v = 32'h72be5d74;  6'd13: v = 32'h80deb1fe;
            6'd14: v = 32'h9bdc06a7;  6'd15: v = 32'hc19bf174;
            6'd16: v = 32'he49b69c1;  6'd17: v = 32'hefbe4786;
            6'd18: v = 32'h0fc19dc6;  6'd19: v = 32'h240ca1cc;
            6'd20: v = 32'h2de92c6f;  6'd21: v = 32'h4a7484aa;
            6'd22: v = 32'h5cb0a9dc;  6'd23: v = 32'h76f988da;
            6'd24: v = 32'h983e5152;  6'd25: v = 32'ha831c66d;
            6'd26: v = 32'hb00327c8;  6'd27: v = 32'hbf597fc7;
            6'd28: v = 32'hc6e00bf3;  6'd29: v = 32'hd5a79147;
            6'd30: v = 32'h06ca6351;  6'd31: v = 32'h14292967;
            6'd32: v = 32'h27b70a85;  6'd33: v = 32'h2e1b2138;
            6'd34: v = 32'h4d2c6dfc;  6'd35: v = 32'h53380d13;
            6'd36: v = 32'h650a7354;  6'd37: v = 32'h766a0abb;
            6'd38: v = 32'h81c2c92e;  6'd39: v = 32'h92722c85;
            6'd40: v = 32'ha2bfe8a1;  6'd41: v = 32'ha81a664b;
            6'd42: v = 32'hc24b8b70;  6'd43: v = 32'hc76c51a3;
            6'd44: v = 32'hd192e819;  6'd45: v = 32'hd6990624;
            6'd46: v = 32'hf40e3585;  6'd47: v = 32'h106aa070;
            6'd48: v = 32'h19a4c116;  6'd49: v = 32'h1e376c08;
            6'd50: v = 32'h2748774c;  6'd51: v = 32'h34b0bcb5;
            6'd52: v = 32'h391c0cb3;  6'd53: v = 32'h4ed8aa4a;
            6'd54: v = 32'h5b9cca4f;  6'd55: v = 32'h682e6ff3;
            6'd56: v = 32'h748f82ee;  6'd57: v = 32'h78a5636f;
            6'd58: v = 32'h84c87814;  6'd59: v = 32'h8cc70208;
            6'd60: v = 32'h90befffa;  6'd61: v = 32'ha4506ceb;
            6'd62: v = 32'hbef9a3f7;  6'd63: v = 32'hc67178f2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: src/sbh_hmem.sv
// Hash state memory: 8 x 32, registered read, entries without a valid bit read as the IV.
`timescale 1ns / 1ps

module sbh_hmem (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sbh_pkg::t_hmem_ctl i_ctl,
    output logic [31:0]       o_rdata
);
    import sbh_pkg::*;

    logic [31:0] r_mem [8];
    logic [7:0]  r_valid;
    logic [31:0] r_rd;
    logic        r_rd_vld;
    logic [2:0]  r_raddr_q;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_ctl.waddr] <= i_ctl.wdata;
        end
        r_rd      <= r_mem[i_ctl.raddr];
        r_raddr_q <= i_ctl.raddr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_valid[i_ctl.raddr];
            if (i_ctl.we) begin
                r_valid[i_ctl.waddr] <= 1'b1;
            end else if (i_ctl.clr) begin
                r_valid[i_ctl.waddr] <= 1'b0;
            end
        end
    end

    assign o_rdata = r_rd_vld ? r_rd : iv_const(r_raddr_q);

endmodule

// File: src/sbh_bmem.sv
// Block memory: sixteen big-endian 32-bit message words, registered read.
`timescale 1ns / 1ps

module sbh_bmem (
    input  logic               i_clk,
    input  sbh_pkg::t_bmem_ctl i_ctl,
    output logic [31:0]        o_rdata
);
    import sbh_pkg::*;

    logic [31:0] r_mem [16];
    logic [31:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_ctl.waddr] <= i_ctl.wdata;
        end
        r_rd <= r_mem[i_ctl.raddr];
    end

    assign o_rdata = r_rd;

endmodule

// File: src/sbh_round.sv
// Round engine: working variables a..h and the sixteen-word schedule shift line.
`timescale 1ns / 1ps

module sbh_round (
    input  logic               i_clk,
    input  sbh_pkg::t_core_ctl i_ctl,
    input  logic [31:0]        i_hdata,
    input  logic [31:0]        i_bdata,
    output logic [31:0]        o_v0
);
    import sbh_pkg::*;

    logic [31:0] r_v [8];
    logic [31:0] r_w [16];
    logic [31:0] w_new;
    logic [31:0] w_cur;
    logic [31:0] ch;
    logic [31:0] maj;
    logic [31:0] t1;
    logic [31:0] t2;

    always_comb begin
        w_new = small_s1(r_w[14]) + r_w[9] + small_s0(r_w[1]) + r_w[0];
        w_cur = (i_ctl.rnd[5:4] == 2'd0) ? i_bdata : w_new;
        ch    = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        maj   = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1    = r_v[7] + big_s1(r_v[4]) + ch + k_const(i_ctl.rnd) + w_cur;
        t2    = big_s0(r_v[0]) + maj;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_shift || i_ctl.add_shift) begin
            // shift toward a; load brings the next hash word in at h
            for (int k = 0; k < 7; k++) begin
                r_v[k] <= r_v[k + 1];
            end
            if (i_ctl.load_shift) begin
                r_v[7] <= i_hdata;
            end
        end else if (i_ctl.round_en) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
        if (i_ctl.round_en) begin
            for (int k = 0; k < 15; k++) begin
                r_w[k] <= r_w[k + 1];
            end
            r_w[15] <= w_cur;
        end
    end

    assign o_v0 = r_v[0];

endmodule

// File: src/sha256_byte_stream_hasher.sv
// Top level of the SHA-256 byte stream hasher: byte packing, padding, round sequencing, digest out.
`timescale 1ns / 1ps

//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------------------
//  in      | to block  | i_in_valid / o_in_stall    | i_data_byte, i_has_byte, i_last_byte
//  out     | from block| o_out_valid / i_out_stall  | o_digest_word, o_word_index, o_last_word
//
//  A byte that neither completes a 64-byte block nor ends a message does not stall.
//  A byte that completes a block stalls the input while the hash state memory is read
//  into a..h, 64 rounds run at one per cycle and a..h are added back into memory.
//  A last transaction adds a setup step, up to 18 padding writes and one or two
//  compressions, then per digest word a read, a capture and the output handshake.
//  Synchronous active-low reset; the hash state reads as the IV after reset, no sweep.

module sha256_byte_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    import sbh_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PSET,
        S_PAD,
        S_LOAD,
        S_ROUND,
        S_ADD,
        S_DRD,
        S_DWAIT
    } t_state;

    t_state      r_state;
    logic [60:0] r_cnt;      // message bytes, wraps mod 2^61
    logic [23:0] r_word;     // last three bytes taken, for the partial word
    logic [3:0]  r_i;        // memory sweep step during load and add
    logic [5:0]  r_t;        // round
    logic [3:0]  r_pwi;      // padding word address
    logic        r_first;    // next padding word carries the pad byte
    logic        r_lenblk;   // this padding block ends with the length
    logic        r_fin;      // message ended, finish once compression is done
    logic        r_padded;   // padding has started
    logic [2:0]  r_k;        // digest word
    logic        r_dcap;     // digest read data arrives this cycle
    logic        r_ovalid;
    logic [31:0] r_odata;
    logic        r_olast;

    t_core_ctl   core_ctl;
    t_hmem_ctl   hmem_ctl;
    t_bmem_ctl   bmem_ctl;
    logic [31:0] hrdata;
    logic [31:0] brdata;
    logic [31:0] v0;
    logic [3:0]  step_prev;
    logic [31:0] part_word;
    logic [31:0] pad_word;
    logic        in_acc;

    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign step_prev  = r_i - 4'd1;

    // Build the padding word: kept message bytes, the pad byte, zeros, the bit length.
    always_comb begin
        unique case (r_cnt[1:0])
            2'd0: part_word = {PadByte, 24'h0};
            2'd1: part_word = {r_word[7:0], PadByte, 16'h0};
            2'd2: part_word = {r_word[15:0], PadByte, 8'h0};
            2'd3: part_word = {r_word, PadByte};
            default: part_word = '0;
        endcase
        pad_word = r_first ? part_word : 32'h0;
        if (r_lenblk && (r_pwi == 4'd14)) begin
            pad_word = pad_word | r_cnt[60:29];
        end
        if (r_lenblk && (r_pwi == 4'd15)) begin
            pad_word = pad_word | {r_cnt[28:0], 3'b000};
        end
    end

    always_comb begin
        core_ctl.load_shift = (r_state == S_LOAD) && (r_i != 4'd0);
        core_ctl.add_shift  = (r_state == S_ADD) && (r_i != 4'd0);
        core_ctl.round_en   = (r_state == S_ROUND);
        core_ctl.rnd        = r_t;

        // Read the hash word for the step; write back the sum one step behind.
        hmem_ctl.raddr = (r_state == S_DRD) ? r_k : r_i[2:0];
        hmem_ctl.we    = (r_state == S_ADD) && (r_i != 4'd0);
        hmem_ctl.clr   = r_dcap;
        hmem_ctl.waddr = r_dcap ? r_k : step_prev[2:0];
        hmem_ctl.wdata = hrdata + v0;

        // Prefetch the message word for the next round.
        bmem_ctl.raddr = (r_state == S_ROUND) ? (r_t[3:0] + 4'd1) : 4'd0;
        if (r_state == S_PAD) begin
            bmem_ctl.we    = 1'b1;
            bmem_ctl.waddr = r_pwi;
            bmem_ctl.wdata = pad_word;
        end else begin
            bmem_ctl.we    = in_acc && i_has_byte && (r_cnt[1:0] == 2'd3);
            bmem_ctl.waddr = r_cnt[5:2];
            bmem_ctl.wdata = {r_word, i_data_byte};
        end
    end

    sbh_hmem u_hmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (hmem_ctl),
        .o_rdata (hrdata)
    );

    sbh_bmem u_bmem (
        .i_clk   (i_clk),
        .i_ctl   (bmem_ctl),
        .o_rdata (brdata)
    );

    sbh_round u_round (
        .i_clk   (i_clk),
        .i_ctl   (core_ctl),
        .i_hdata (hrdata),
        .i_bdata (brdata),
        .o_v0    (v0)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_i      <= '0;
            r_t      <= '0;
            r_pwi    <= '0;
            r_first  <= 1'b0;
            r_lenblk <= 1'b0;
            r_fin    <= 1'b0;
            r_padded <= 1'b0;
            r_k      <= '0;
            r_dcap   <= 1'b0;
            r_ovalid <= 1'b0;
            r_olast  <= 1'b0;
        end else begin
            r_dcap <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (i_has_byte) begin
                            r_cnt  <= r_cnt + 61'd1;
                            r_word <= {r_word[15:0], i_data_byte};
                            r_fin  <= i_last_byte;
                            if (r_cnt[5:0] == 6'd63) begin
                                r_state <= S_LOAD;
                                r_i     <= '0;
                            end else if (i_last_byte) begin
                                r_state <= S_PSET;
                            end
                        end else if (i_last_byte) begin
                            r_fin   <= 1'b1;
                            r_state <= S_PSET;
                        end
                    end
                end
                S_PSET: begin
                    // start padding at the word that holds the pad byte
                    r_pwi    <= r_cnt[5:2];
                    r_first  <= 1'b1;
                    r_lenblk <= (r_cnt[5:0] < LenPos);
                    r_padded <= 1'b1;
                    r_state  <= S_PAD;
                end
                S_PAD: begin
                    r_first <= 1'b0;
                    if (r_pwi == 4'd15) begin
                        r_state <= S_LOAD;
                        r_i     <= '0;
                    end else begin
                        r_pwi <= r_pwi + 4'd1;
                    end
                end
                S_LOAD: begin
                    r_i <= r_i + 4'd1;
                    if (r_i == 4'd8) begin
                        r_state <= S_ROUND;
                        r_t     <= '0;
                    end
                end
                S_ROUND: begin
                    r_t <= r_t + 6'd1;
                    if (r_t == 6'd63) begin
                        r_state <= S_ADD;
                        r_i     <= '0;
                    end
                end
                S_ADD: begin
                    r_i <= r_i + 4'd1;
                    if (r_i == 4'd8) begin
                        priority if (!r_fin) begin
                            r_state <= S_IDLE;
                        end else if (!r_padded) begin
                            r_state <= S_PSET;
                        end else if (!r_lenblk) begin
                            // length did not fit: one more block, zeros then length
                            r_pwi    <= '0;
                            r_first  <= 1'b0;
                            r_lenblk <= 1'b1;
                            r_state  <= S_PAD;
                        end else begin
                            r_k     <= '0;
                            r_state <= S_DRD;
                        end
                    end
                end
                S_DRD: begin
                    r_dcap  <= 1'b1;
                    r_state <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (r_dcap) begin
                        // capture the word; its entry goes back to the IV
                        r_odata  <= hrdata;
                        r_olast  <= (r_k == 3'd7);
                        r_ovalid <= 1'b1;
                    end else if (r_ovalid && !i_out_stall) begin
                        r_ovalid <= 1'b0;
                        if (r_k == 3'd7) begin
                            r_state  <= S_IDLE;
                            r_cnt    <= '0;
                            r_fin    <= 1'b0;
                            r_padded <= 1'b0;
                        end else begin
                            r_k     <= r_k + 3'd1;
                            r_state <= S_DRD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_digest_word = r_odata;
    assign o_word_index  = r_k;
    assign o_last_word   = r_olast;

endmodule

// File: src/sbh_checker.sv
// Port-level checker for the hasher, bound to the top level.
`timescale 1ns / 1ps
`include "sha256_byte_stream_hasher_macros.svh"

module sbh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_digest_word,
    input logic [2:0]  o_word_index,
    input logic        o_last_word
);

    // hold a stalled transaction
    `SBH_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid, "out valid dropped")
    `SBH_ASSERT(a_out_stable, o_out_valid && i_out_stall |=> $stable(o_digest_word), "word moved")
    // the last flag goes with word seven only
    `SBH_ASSERT(a_last_idx, o_out_valid |-> (o_last_word == (o_word_index == 3'd7)), "last mismatch")
    // no byte is taken while a digest word is pending
    `SBH_ASSERT(a_in_blocked, o_out_valid |-> o_in_stall, "input open during digest")
    `SBH_ASSERT_RST(a_rst_quiet, !i_rst_n |=> !o_out_valid, "out valid after reset")

endmodule

bind sha256_byte_stream_hasher sbh_checker u_sbh_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_digest_word (o_digest_word),
    .o_word_index  (o_word_index),
    .o_last_word   (o_last_word)
);
